// ----- rtl/cpei_pkg.sv -----
// ----------------------------------------------------------------------------
// cpei_pkg - shared definitions for the clamped pose error integrator
// Default widths, register map, reset values and the unit status struct.
// ----------------------------------------------------------------------------
package cpei_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 20;

    // projection quotient width, saturates at 2^63-1
    localparam int Q_WIDTH   = 63;
    // signed working width of the projected sum before clamping
    localparam int RES_WIDTH = 64;
    // multiplier bits consumed per cycle
    localparam int MUL_CHUNK = 16;

    localparam int LIMIT_WIDTH    = 31;
    localparam int THR_WIDTH      = 32;
    localparam int ADDR_WIDTH     = 4;
    localparam int APB_DATA_WIDTH = 32;

    localparam logic [1:0] REG_POS_LIMIT = 2'd0;
    localparam logic [1:0] REG_ROT_LIMIT = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;

    localparam logic [LIMIT_WIDTH-1:0] POS_LIMIT_RST = 31'd157286400;
    localparam logic [LIMIT_WIDTH-1:0] ROT_LIMIT_RST = 31'd104857600;
    localparam logic [THR_WIDTH-1:0]   THR_RST       = 32'd1099512;

    typedef struct packed {
        logic busy;
        logic done;
    } cpei_stat_t;

endpackage

// ----- rtl/clamped_pose_error_integrator.sv -----
// ----------------------------------------------------------------------------
// clamped_pose_error_integrator - pose error integrator with anti-windup clamp
// Integrates position error per axis and orientation error by projection,
// clamping each integral to a programmable limit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one control tick's pose error per
//   transaction; output channel (out_valid/out_ready) returns the six updated
//   integrals, one transaction per input. Limits and the small-norm threshold
//   sit on the APB port at byte addresses 0, 4 and 8; pready is tied high.
//   Timing: one transaction at a time. When the error norm is below threshold
//   the projection is skipped and each orientation integral becomes its
//   clamped error. The work runs on the shared 16-bit-per-cycle multiplier
//   (six products, nine with the projection) and, for the projection, on the
//   63-step quotient divider. in_ready returns in the same cycle that
//   out_valid rises.
//   A result that is not taken waits in the output register; the next input
//   is accepted meanwhile, but its result holds in the final step until the
//   output register frees.
//   Reset clears all integrals to zero, loads the default limits and empties
//   the output register.
// ----------------------------------------------------------------------------
module clamped_pose_error_integrator #(
    parameter int DATA_WIDTH = cpei_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cpei_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [cpei_pkg::ADDR_WIDTH-1:0]       paddr,
    input  logic [cpei_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [cpei_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                  pready,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [DATA_WIDTH-1:0]          pos_err_x,
    input  logic signed [DATA_WIDTH-1:0]          pos_err_y,
    input  logic signed [DATA_WIDTH-1:0]          pos_err_z,
    input  logic signed [DATA_WIDTH-1:0]          rot_err_x,
    input  logic signed [DATA_WIDTH-1:0]          rot_err_y,
    input  logic signed [DATA_WIDTH-1:0]          rot_err_z,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [DATA_WIDTH-1:0]          pos_int_x,
    output logic signed [DATA_WIDTH-1:0]          pos_int_y,
    output logic signed [DATA_WIDTH-1:0]          pos_int_z,
    output logic signed [DATA_WIDTH-1:0]          rot_int_x,
    output logic signed [DATA_WIDTH-1:0]          rot_int_y,
    output logic signed [DATA_WIDTH-1:0]          rot_int_z
);
    import cpei_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int SW = 2 * DW;            // dot products and e.e
    localparam int NW = SW + FB;           // quotient numerator
    localparam int PW = Q_WIDTH + DW;      // multiplier product
    localparam int RW = RES_WIDTH;

    localparam logic signed [RW-1:0] D_MAX = (RW'(1) <<< (DW - 1)) - RW'(1);
    localparam logic signed [RW-1:0] D_MIN = -D_MAX - RW'(1);
    localparam logic [PW-1:0]        P_SAT = PW'(1) << (Q_WIDTH - 1);
    localparam logic [1:0]           LAST_IDX = 2'd2;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_POS  = 4'd1;   // position add and clamp, per axis
    localparam logic [3:0] S_MEE  = 4'd2;   // start e_i * e_i
    localparam logic [3:0] S_WEE  = 4'd3;
    localparam logic [3:0] S_MLE  = 4'd4;   // start |L_i| * |e_i|
    localparam logic [3:0] S_WLE  = 4'd5;
    localparam logic [3:0] S_SIGN = 4'd6;   // signed dot magnitude, path choice
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_WDIV = 4'd8;
    localparam logic [3:0] S_MPR  = 4'd9;   // start q * |e_i|
    localparam logic [3:0] S_WPR  = 4'd10;
    localparam logic [3:0] S_RCL  = 4'd11;  // clamp projected sum
    localparam logic [3:0] S_SKIP = 4'd12;  // small norm: integral becomes e
    localparam logic [3:0] S_OUT  = 4'd13;

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        return v[DW-1] ? (~v + 1'b1) : v;
    endfunction

    // clamp to +/- limit, then to the signed data range
    function automatic logic signed [DW-1:0] clamp_val(
        input logic signed [RW-1:0]   v,
        input logic [LIMIT_WIDTH-1:0] lim
    );
        logic signed [RW-1:0] lp;
        logic signed [RW-1:0] ln;
        logic signed [RW-1:0] t;
        lp = $signed(RW'(lim));
        ln = -lp;
        t  = v;
        if (t > lp)    t = lp;
        if (t < ln)    t = ln;
        if (t > D_MAX) t = D_MAX;
        if (t < D_MIN) t = D_MIN;
        return t[DW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [LIMIT_WIDTH-1:0] pos_limit_reg;
    logic [LIMIT_WIDTH-1:0] rot_limit_reg;
    logic [THR_WIDTH-1:0]   thr_reg;
    logic                   cfg_wr;
    logic [1:0]             reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_idx = paddr[ADDR_WIDTH-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_limit_reg <= POS_LIMIT_RST;
            rot_limit_reg <= ROT_LIMIT_RST;
            thr_reg       <= THR_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_POS_LIMIT: pos_limit_reg <= pwdata[LIMIT_WIDTH-1:0];
                REG_ROT_LIMIT: rot_limit_reg <= pwdata[LIMIT_WIDTH-1:0];
                REG_THRESHOLD: thr_reg       <= pwdata[THR_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_POS_LIMIT: prdata = APB_DATA_WIDTH'(pos_limit_reg);
            REG_ROT_LIMIT: prdata = APB_DATA_WIDTH'(rot_limit_reg);
            REG_THRESHOLD: prdata = APB_DATA_WIDTH'(thr_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath storage
    // ------------------------------------------------------------------
    logic [3:0]                 state_reg;
    logic [3:0]                 state_next;
    logic [1:0]                 idx_reg;
    logic                       idx_last;

    logic signed [DW-1:0]       perr_reg    [3];
    logic signed [DW-1:0]       e_reg       [3];
    logic signed [DW-1:0]       pos_int_reg [3];
    logic signed [DW-1:0]       rot_int_reg [3];
    logic signed [DW-1:0]       out_pos_reg [3];
    logic signed [DW-1:0]       out_rot_reg [3];
    logic                       out_valid_reg;

    logic [SW-1:0]              ee_reg;
    logic [SW-1:0]              dpos_reg;
    logic [SW-1:0]              dneg_reg;
    logic [SW-1:0]              dmag_reg;
    logic                       dneg_sign_reg;
    logic [Q_WIDTH-1:0]         q_reg;
    logic signed [RW-1:0]       r_reg;

    // shared units
    logic                       mul_start;
    logic [Q_WIDTH-1:0]         mul_a;
    logic [DW-1:0]              mul_b;
    logic [PW-1:0]              mul_p;
    cpei_stat_t                 mul_stat;
    logic                       div_start;
    logic [NW-1:0]              div_num;
    logic [Q_WIDTH-1:0]         div_q;
    cpei_stat_t                 div_stat;

    logic signed [DW-1:0]       e_sel;
    logic signed [DW-1:0]       l_sel;
    logic [DW-1:0]              em_sel;
    logic signed [RW-1:0]       pos_sum;
    logic                       dot_neg;
    logic                       small_norm;
    logic [PW-1:0]              prx;
    logic [Q_WIDTH-1:0]         pm;
    logic signed [RW-1:0]       r_calc;
    logic                       out_load;

    assign idx_last = idx_reg == LAST_IDX;
    assign e_sel    = e_reg[idx_reg];
    assign l_sel    = rot_int_reg[idx_reg];
    assign em_sel   = mag(e_sel);
    assign pos_sum  = RW'(pos_int_reg[idx_reg]) + RW'(perr_reg[idx_reg]);
    assign dot_neg  = l_sel[DW-1] != e_sel[DW-1];

    // e.e of zero also takes the short path (no division by zero)
    assign small_norm = (ee_reg < SW'(thr_reg)) || (ee_reg == '0);

    // projection magnitude, saturated at 2^62, then signed add to e_i
    assign prx    = mul_p >> FB;
    assign pm     = (prx > P_SAT) ? P_SAT[Q_WIDTH-1:0] : prx[Q_WIDTH-1:0];
    assign r_calc = (dneg_sign_reg != e_sel[DW-1]) ? RW'(e_sel) - $signed({1'b0, pm})
                                                   : RW'(e_sel) + $signed({1'b0, pm});

    assign mul_start = (state_reg == S_MEE) || (state_reg == S_MLE) || (state_reg == S_MPR);
    assign mul_b     = em_sel;
    always_comb
    begin
        case (state_reg)
            S_MPR:   mul_a = q_reg;
            S_MLE:   mul_a = Q_WIDTH'(mag(l_sel));
            default: mul_a = Q_WIDTH'(em_sel);
        endcase
    end

    assign div_start = state_reg == S_DIV;
    assign div_num   = NW'(dmag_reg) << FB;

    cpei_mul #(
        .A_WIDTH (Q_WIDTH),
        .B_WIDTH (DW),
        .CHUNK   (MUL_CHUNK)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .p     (mul_p),
        .stat  (mul_stat)
    );

    cpei_div #(
        .NUM_WIDTH (NW),
        .DEN_WIDTH (SW),
        .QUO_WIDTH (Q_WIDTH)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (ee_reg),
        .q     (div_q),
        .stat  (div_stat)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign in_ready = state_reg == S_IDLE;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_POS;
            S_POS:  if (idx_last) state_next = S_MEE;
            S_MEE:  state_next = S_WEE;
            S_WEE:  if (mul_stat.done) state_next = S_MLE;
            S_MLE:  state_next = S_WLE;
            S_WLE:  if (mul_stat.done) state_next = idx_last ? S_SIGN : S_MEE;
            S_SIGN: state_next = small_norm ? S_SKIP : S_DIV;
            S_DIV:  state_next = S_WDIV;
            S_WDIV: if (div_stat.done) state_next = S_MPR;
            S_MPR:  state_next = S_WPR;
            S_WPR:  if (mul_stat.done) state_next = S_RCL;
            S_RCL:  state_next = idx_last ? S_OUT : S_MPR;
            S_SKIP: if (idx_last) state_next = S_OUT;
            S_OUT:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control state and integrals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                pos_int_reg[i] <= '0;
                rot_int_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                end
                S_POS:
                begin
                    pos_int_reg[idx_reg] <= clamp_val(pos_sum, pos_limit_reg);
                    idx_reg <= idx_last ? 2'd0 : idx_reg + 2'd1;
                end
                S_WLE:
                begin
                    if (mul_stat.done)
                        idx_reg <= idx_last ? 2'd0 : idx_reg + 2'd1;
                end
                S_SKIP:
                begin
                    rot_int_reg[idx_reg] <= clamp_val(RW'(e_sel), rot_limit_reg);
                    idx_reg <= idx_last ? 2'd0 : idx_reg + 2'd1;
                end
                S_RCL:
                begin
                    rot_int_reg[idx_reg] <= clamp_val(r_reg, rot_limit_reg);
                    idx_reg <= idx_last ? 2'd0 : idx_reg + 2'd1;
                end
                default: ;
            endcase

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    perr_reg[0] <= pos_err_x;
                    perr_reg[1] <= pos_err_y;
                    perr_reg[2] <= pos_err_z;
                    e_reg[0]    <= rot_err_x;
                    e_reg[1]    <= rot_err_y;
                    e_reg[2]    <= rot_err_z;
                    ee_reg      <= '0;
                    dpos_reg    <= '0;
                    dneg_reg    <= '0;
                end
            end
            S_WEE:
            begin
                if (mul_stat.done)
                    ee_reg <= ee_reg + mul_p[SW-1:0];
            end
            S_WLE:
            begin
                if (mul_stat.done)
                begin
                    if (dot_neg)
                        dneg_reg <= dneg_reg + mul_p[SW-1:0];
                    else
                        dpos_reg <= dpos_reg + mul_p[SW-1:0];
                end
            end
            S_SIGN:
            begin
                if (dpos_reg >= dneg_reg)
                begin
                    dmag_reg      <= dpos_reg - dneg_reg;
                    dneg_sign_reg <= 1'b0;
                end
                else
                begin
                    dmag_reg      <= dneg_reg - dpos_reg;
                    dneg_sign_reg <= 1'b1;
                end
            end
            S_WDIV:
            begin
                if (div_stat.done)
                    q_reg <= div_q;
            end
            S_WPR:
            begin
                if (mul_stat.done)
                    r_reg <= r_calc;
            end
            default: ;
        endcase

        if (out_load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_pos_reg[i] <= pos_int_reg[i];
                out_rot_reg[i] <= rot_int_reg[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_int_x = out_pos_reg[0];
    assign pos_int_y = out_pos_reg[1];
    assign pos_int_z = out_pos_reg[2];
    assign rot_int_x = out_rot_reg[0];
    assign rot_int_y = out_rot_reg[1];
    assign rot_int_z = out_rot_reg[2];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_mul_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    a_div_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (ee_reg != '0) && !div_stat.busy)
        else $error("divider started with zero divisor or while busy");

    a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result loaded outside final step");

    a_accept_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> (state_reg == S_POS) && (idx_reg == 2'd0))
        else $error("accepted transaction did not restart the sequence");

endmodule

// ----- rtl/cpei_mul.sv -----
// ----------------------------------------------------------------------------
// cpei_mul - iterative unsigned multiplier
// Multiplies a by b, CHUNK bits of b per cycle, most significant chunk first.
// ----------------------------------------------------------------------------
module cpei_mul #(
    parameter int A_WIDTH = cpei_pkg::Q_WIDTH,
    parameter int B_WIDTH = cpei_pkg::DATA_WIDTH_DEF,
    parameter int CHUNK   = cpei_pkg::MUL_CHUNK
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [A_WIDTH-1:0]         a,
    input  logic [B_WIDTH-1:0]         b,
    output logic [A_WIDTH+B_WIDTH-1:0] p,
    output cpei_pkg::cpei_stat_t       stat
);
    import cpei_pkg::*;

    localparam int NCH  = (B_WIDTH + CHUNK - 1) / CHUNK;
    localparam int BPW  = NCH * CHUNK;
    localparam int PADW = A_WIDTH + BPW;
    localparam int CNTW = $clog2(NCH + 1);

    logic [A_WIDTH-1:0]       a_reg;
    logic [BPW-1:0]           b_reg;
    logic [PADW-1:0]          acc_reg;
    logic [CNTW-1:0]          cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [A_WIDTH+CHUNK-1:0] part;

    assign part = a_reg * b_reg[BPW-1 -: CHUNK];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(NCH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= BPW'(b);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= (acc_reg << CHUNK) + PADW'(part);
            b_reg   <= b_reg << CHUNK;
        end
    end

    assign p         = acc_reg[A_WIDTH+B_WIDTH-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- rtl/cpei_div.sv -----
// ----------------------------------------------------------------------------
// cpei_div - restoring divider with saturated quotient
// One quotient bit per cycle; a quotient of 2^QUO_WIDTH or more gives all ones.
// ----------------------------------------------------------------------------
module cpei_div #(
    parameter int NUM_WIDTH = 2 * cpei_pkg::DATA_WIDTH_DEF + cpei_pkg::FRAC_BITS_DEF,
    parameter int DEN_WIDTH = 2 * cpei_pkg::DATA_WIDTH_DEF,
    parameter int QUO_WIDTH = cpei_pkg::Q_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [NUM_WIDTH-1:0]   num,
    input  logic [DEN_WIDTH-1:0]   den,
    output logic [QUO_WIDTH-1:0]   q,
    output cpei_pkg::cpei_stat_t   stat
);
    import cpei_pkg::*;

    localparam int XW   = DEN_WIDTH + QUO_WIDTH;
    localparam int CNTW = $clog2(QUO_WIDTH + 1);

    logic [DEN_WIDTH-1:0] rem_reg;
    logic [DEN_WIDTH-1:0] den_reg;
    logic [QUO_WIDTH-1:0] nlo_reg;
    logic [QUO_WIDTH-1:0] quo_reg;
    logic                 ovf_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [XW-1:0]        numx;
    logic                 ovf;
    logic [DEN_WIDTH:0]   rem2;
    logic [DEN_WIDTH:0]   diff;
    logic                 ge;

    assign numx = XW'(num);
    assign ovf  = numx >= (XW'(den) << QUO_WIDTH);
    assign rem2 = {rem_reg, nlo_reg[QUO_WIDTH-1]};
    assign ge   = rem2 >= {1'b0, den_reg};
    assign diff = rem2 - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(QUO_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // remainder starts at the bits above the quotient field
            rem_reg <= numx[XW-1:QUO_WIDTH];
            nlo_reg <= numx[QUO_WIDTH-1:0];
            den_reg <= den;
            quo_reg <= '0;
            ovf_reg <= ovf;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_WIDTH-1:0] : rem2[DEN_WIDTH-1:0];
            nlo_reg <= nlo_reg << 1;
            quo_reg <= {quo_reg[QUO_WIDTH-2:0], ge};
        end
    end

    assign q         = ovf_reg ? '1 : quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
